### rtl/core/gwb_pkg.sv
package gwb_pkg;

    localparam int DEF_MAX_PIXELS     = 8388608;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    // op codes of the input beat
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_ARM   = 2'd1;
    localparam logic [1:0] OP_UNITY = 2'd2;

    // channel select for the shared divider
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       div_load;
        logic       div_step;
        logic       gain_write;
        logic [1:0] chan;
    } gwb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic calc_req;
    } gwb_stat_t;

endpackage

### rtl/core/gwb_divider.sv
module gwb_divider #(
    parameter int REM_W = 35,
    parameter int QW    = 17
) (
    input  logic             aclk,
    input  logic             load,
    input  logic             step,
    input  logic [REM_W-1:0] rem_init,
    input  logic [QW-1:0]    num_lo,
    input  logic [REM_W-1:0] den,
    output logic [QW-1:0]    quot
);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] den_reg, den_next;
    logic [QW-1:0]    shift_reg, shift_next;
    logic [REM_W:0]   trial;
    logic             qbit;

    // restoring division, one quotient bit per step; numerator bits leave the
    // top of shift_reg while quotient bits enter at the bottom
    always_comb begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        shift_next = shift_reg;
        trial      = {rem_reg, shift_reg[QW-1]};
        qbit       = (trial >= {1'b0, den_reg});
        if (load) begin
            rem_next   = rem_init;
            den_next   = den;
            shift_next = num_lo;
        end else if (step) begin
            if (qbit) begin
                rem_next = REM_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[REM_W-1:0];
            end
            shift_next = {shift_reg[QW-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        shift_reg <= shift_next;
    end

    assign quot = shift_reg;

endmodule

### rtl/core/gwb_datapath.sv
module gwb_datapath import gwb_pkg::*; #(
    parameter int MAX_PIXELS     = DEF_MAX_PIXELS,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  gwb_cmd_t  cmd,
    output gwb_stat_t stat,
    input  logic [1:0] s_op,
    input  logic [7:0] s_blue_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_red_in,
    input  logic       s_frame_end,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic       m_frame_end_out
);

    localparam int     GW      = GAIN_FRAC_BITS + 2;
    localparam longint SUM_MAX = 255 * longint'(MAX_PIXELS);
    localparam int     SUM_W   = $clog2(SUM_MAX + 1);
    localparam int     CNT_W   = $clog2(MAX_PIXELS + 1);
    localparam int     TOT_W   = SUM_W + 2;
    localparam int     NUM_W   = TOT_W + GAIN_FRAC_BITS + 1;
    localparam int     QW      = GAIN_FRAC_BITS + 9;
    localparam int     P_W     = 8 + GW + 1;

    localparam logic [GW-1:0]    UNITY_GAIN = GW'(1) << GAIN_FRAC_BITS;
    localparam logic [GW-1:0]    GAIN_HIGH  = GW'(3) << GAIN_FRAC_BITS;
    localparam logic [GW-1:0]    GAIN_LOW   = GW'(((3 << GAIN_FRAC_BITS) + 5) / 10);
    localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(MAX_PIXELS);
    localparam logic [P_W-1:0]   ROUND_HALF = P_W'(1) << (GAIN_FRAC_BITS - 1);

    logic [GW-1:0]    gain_reg [3];
    logic [GW-1:0]    gain_next [3];
    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             armed_reg, armed_next;
    logic             measuring_reg, measuring_next;
    logic             frame_start_reg, frame_start_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       res_reg [3];
    logic [7:0]       res_next [3];
    logic             fe_out_reg;

    logic [7:0]       pix [3];
    logic [P_W-1:0]   prod [3];
    logic             is_pixel;
    logic             start_meas;
    logic             meas_now;

    logic [SUM_W-1:0] sel_sum;
    logic [TOT_W-1:0] total;
    logic [NUM_W-1:0] num;
    logic [TOT_W-1:0] den;
    logic [QW-1:0]    quot;
    logic [QW:0]      quot_inc;
    logic [QW-1:0]    quot_rnd;
    logic [GW-1:0]    new_gain;

    assign pix[CH_BLUE]  = s_blue_in;
    assign pix[CH_GREEN] = s_green_in;
    assign pix[CH_RED]   = s_red_in;

    assign is_pixel   = (s_op == OP_PIXEL);
    assign start_meas = frame_start_reg && armed_reg;
    assign meas_now   = measuring_reg || start_meas;

    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.calc_req = is_pixel && s_frame_end && meas_now;

    // per-channel scale, round half up, saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = (P_W'(pix[c]) * P_W'(gain_reg[c]) + ROUND_HALF) >> GAIN_FRAC_BITS;
            res_next[c] = (prod[c] > P_W'(255)) ? 8'hff : prod[c][7:0];
        end
    end

    // divider operands for the selected channel
    assign sel_sum = sum_reg[cmd.chan];
    assign total   = TOT_W'(sum_reg[CH_BLUE]) + TOT_W'(sum_reg[CH_GREEN])
                   + TOT_W'(sum_reg[CH_RED]);
    assign num     = {total, {(GAIN_FRAC_BITS + 1){1'b0}}};
    assign den     = TOT_W'(sel_sum) + (TOT_W'(sel_sum) << 1);

    gwb_divider #(
        .REM_W (TOT_W),
        .QW    (QW)
    ) u_div (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .rem_init (TOT_W'(num[NUM_W-1:QW])),
        .num_lo   (num[QW-1:0]),
        .den      (den),
        .quot     (quot)
    );

    assign quot_inc = (QW + 1)'(quot) + (QW + 1)'(1);
    assign quot_rnd = quot_inc[QW:1];

    always_comb begin
        if (sel_sum < SUM_W'(count_reg) || sel_sum == '0) begin
            new_gain = UNITY_GAIN;
        end else if (quot_rnd < QW'(GAIN_LOW)) begin
            new_gain = GAIN_LOW;
        end else if (quot_rnd > QW'(GAIN_HIGH)) begin
            new_gain = GAIN_HIGH;
        end else begin
            new_gain = quot_rnd[GW-1:0];
        end
    end

    always_comb begin
        gain_next        = gain_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        armed_next       = armed_reg;
        measuring_next   = measuring_reg;
        frame_start_next = frame_start_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        if (cmd.gain_write) begin
            gain_next[cmd.chan] = new_gain;
        end

        if (cmd.accept) begin
            case (s_op)
                OP_ARM: begin
                    armed_next = 1'b1;
                end
                OP_UNITY: begin
                    for (int c = 0; c < 3; c++) begin
                        gain_next[c] = UNITY_GAIN;
                    end
                end
                OP_PIXEL: begin
                    m_valid_next = 1'b1;
                    if (start_meas) begin
                        armed_next = 1'b0;
                        for (int c = 0; c < 3; c++) begin
                            sum_next[c] = '0;
                        end
                        count_next = '0;
                    end
                    // pixels beyond the size limit are balanced but not summed
                    if (meas_now && count_next < CNT_LIMIT) begin
                        for (int c = 0; c < 3; c++) begin
                            sum_next[c] = sum_next[c] + SUM_W'(pix[c]);
                        end
                        count_next = count_next + CNT_W'(1);
                    end
                    measuring_next   = meas_now && !s_frame_end;
                    frame_start_next = s_frame_end;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                gain_reg[c] <= UNITY_GAIN;
                sum_reg[c]  <= '0;
            end
            count_reg       <= '0;
            armed_reg       <= 1'b0;
            measuring_reg   <= 1'b0;
            frame_start_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            gain_reg        <= gain_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            armed_reg       <= armed_next;
            measuring_reg   <= measuring_next;
            frame_start_reg <= frame_start_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && is_pixel) begin
            res_reg    <= res_next;
            fe_out_reg <= s_frame_end;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = res_reg[CH_RED];
    assign m_green_out     = res_reg[CH_GREEN];
    assign m_blue_out      = res_reg[CH_BLUE];
    assign m_frame_end_out = fe_out_reg;

endmodule

### rtl/core/gwb_ctrl.sv
module gwb_ctrl import gwb_pkg::*; #(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gwb_stat_t stat,
    output gwb_cmd_t  cmd
);

    localparam int QW    = GAIN_FRAC_BITS + 9;
    localparam int ITR_W = $clog2(QW);

    typedef enum logic [3:0] {
        S_RUN   = 4'b0001,
        S_LOAD  = 4'b0010,
        S_STEP  = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       chan_reg, chan_next;
    logic [ITR_W-1:0] iter_reg, iter_next;
    logic             take;

    assign s_ready = (state_reg == S_RUN) && stat.out_free;
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        iter_next  = iter_reg;
        case (state_reg)
            S_RUN: begin
                // a measured frame has closed: work out the three gains
                if (take && stat.calc_req) begin
                    state_next = S_LOAD;
                    chan_next  = CH_BLUE;
                end
            end
            S_LOAD: begin
                state_next = S_STEP;
                iter_next  = ITR_W'(QW - 1);
            end
            S_STEP: begin
                if (iter_reg == '0) begin
                    state_next = S_WRITE;
                end else begin
                    iter_next = iter_reg - ITR_W'(1);
                end
            end
            S_WRITE: begin
                if (chan_reg == CH_RED) begin
                    state_next = S_RUN;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
            chan_reg  <= CH_BLUE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            iter_reg  <= iter_next;
        end
    end

    assign cmd.accept     = take;
    assign cmd.div_load   = (state_reg == S_LOAD);
    assign cmd.div_step   = (state_reg == S_STEP);
    assign cmd.gain_write = (state_reg == S_WRITE);
    assign cmd.chan       = chan_reg;

endmodule

### rtl/core/gray_world_white_balance.sv
// Output: a pixel beat shows on the m_ side in the cycle after it is accepted.
// Throughput: one beat per cycle while the output is not stalled. After the last
// pixel of a measured frame the input holds off while one shared bit-serial
// divider works out the blue, green and red gains.
// Reset: synchronous, active low; gains return to unity, no calibration pending.
module gray_world_white_balance import gwb_pkg::*; #(
    parameter int MAX_PIXELS     = DEF_MAX_PIXELS,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_blue_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_red_in,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic       m_frame_end_out
);

    gwb_cmd_t  cmd;
    gwb_stat_t stat;

    gwb_ctrl #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gwb_datapath #(
        .MAX_PIXELS     (MAX_PIXELS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_op            (s_op),
        .s_blue_in       (s_blue_in),
        .s_green_in      (s_green_in),
        .s_red_in        (s_red_in),
        .s_frame_end     (s_frame_end),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end_out (m_frame_end_out)
    );

endmodule

### rtl/core/gwb_checker.sv
module gwb_checker import gwb_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_op,
    input logic [7:0] s_blue_in,
    input logic [7:0] s_green_in,
    input logic [7:0] s_red_in,
    input logic       s_frame_end,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red_out,
    input logic [7:0] m_green_out,
    input logic [7:0] m_blue_out,
    input logic       m_frame_end_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_frame_end_out))
        else $error("result beat changed while stalled");

    // every accepted pixel appears next cycle with its frame mark
    a_pixel_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_PIXEL
            |=> m_valid && m_frame_end_out == $past(s_frame_end))
        else $error("pixel beat lost or frame mark wrong");

    // control ops give no result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op != OP_PIXEL && (!m_valid || m_ready) |=> !m_valid)
        else $error("result beat for a non-pixel op");

    // black stays black whatever the gains
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_PIXEL && s_red_in == 8'd0
            && s_green_in == 8'd0 && s_blue_in == 8'd0
            |=> m_red_out == 8'd0 && m_green_out == 8'd0 && m_blue_out == 8'd0)
        else $error("black pixel not black on output");

endmodule

bind gray_world_white_balance gwb_checker u_gwb_checker (.*);

### verif/gray_world_white_balance_test.sv
`timescale 1ns / 100ps

module gray_world_white_balance_test;
    import gwb_pkg::*;

    localparam int FRAC_BITS  = DEF_GAIN_FRAC_BITS;
    localparam int PIXEL_CAP  = DEF_MAX_PIXELS;
    localparam int UNITY      = 1 << FRAC_BITS;
    localparam int GAIN_CEIL  = 3 << FRAC_BITS;
    localparam int GAIN_FLOOR = ((3 << FRAC_BITS) + 5) / 10;
    localparam int DIV_CYCLES = 3 * (FRAC_BITS + 11);
    localparam int RANDOM_BEATS = 650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 400;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
        logic       fixed;
        pixel_out_t want;
    } beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = OP_PIXEL;
    logic [7:0] s_blue_in = 8'd0;
    logic [7:0] s_green_in = 8'd0;
    logic [7:0] s_red_in = 8'd0;
    logic       s_frame_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_red_out;
    logic [7:0] m_green_out;
    logic [7:0] m_blue_out;
    logic       m_frame_end_out;

    gray_world_white_balance dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_blue_in       (s_blue_in),
        .s_green_in      (s_green_in),
        .s_red_in        (s_red_in),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end_out (m_frame_end_out)
    );

    always #1 aclk = ~aclk;

    // white balance state as seen from outside
    logic [9:0]      wb_gain_blue, wb_gain_green, wb_gain_red;
    bit              cal_armed, cal_running, frame_start;
    longint unsigned acc_blue, acc_green, acc_red;
    int unsigned     acc_pixels;

    pixel_out_t balanced_pixels[$];
    beat_t      directed_beats[$];
    int         mismatches = 0;
    int         beats_counted = 0;
    int         results_seen = 0;
    int         cycles = 0;
    bit         tx_calm = 1'b0;

    function automatic logic [7:0] balance_channel(logic [7:0] v, logic [9:0] gain);
        longint unsigned p;
        p = (longint'(v) * longint'(gain) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function automatic logic [9:0] gray_world_gain(longint unsigned total,
                                                   longint unsigned chan,
                                                   int unsigned count);
        longint unsigned q;
        // channel mean below one: leave it at unity
        if (chan < 64'(count) || chan == 0)
            return UNITY[9:0];
        q = ((total << (FRAC_BITS + 1)) / (3 * chan) + 1) >> 1;
        if (q < 64'(GAIN_FLOOR))
            q = 64'(GAIN_FLOOR);
        if (q > 64'(GAIN_CEIL))
            q = 64'(GAIN_CEIL);
        return q[9:0];
    endfunction

    task automatic reset_balance_state();
        wb_gain_blue  = UNITY[9:0];
        wb_gain_green = UNITY[9:0];
        wb_gain_red   = UNITY[9:0];
        cal_armed     = 1'b0;
        cal_running   = 1'b0;
        frame_start   = 1'b1;
        acc_blue      = 0;
        acc_green     = 0;
        acc_red       = 0;
        acc_pixels    = 0;
    endtask

    // advance the state by one accepted beat and queue the pixel it yields
    task automatic balance_beat(beat_t bt);
        pixel_out_t px;
        longint unsigned total;
        if (bt.op != OP_UNUSED)
            beats_counted++;
        if (bt.op == OP_ARM) begin
            cal_armed = 1'b1;
        end else if (bt.op == OP_UNITY) begin
            wb_gain_blue  = UNITY[9:0];
            wb_gain_green = UNITY[9:0];
            wb_gain_red   = UNITY[9:0];
        end else if (bt.op == OP_PIXEL) begin
            if (frame_start && cal_armed) begin
                cal_armed   = 1'b0;
                cal_running = 1'b1;
                acc_blue    = 0;
                acc_green   = 0;
                acc_red     = 0;
                acc_pixels  = 0;
            end
            px.red       = balance_channel(bt.red, wb_gain_red);
            px.green     = balance_channel(bt.green, wb_gain_green);
            px.blue      = balance_channel(bt.blue, wb_gain_blue);
            px.frame_end = bt.frame_end;
            balanced_pixels.push_back(bt.fixed ? bt.want : px);
            if (cal_running) begin
                if (acc_pixels < PIXEL_CAP) begin
                    acc_blue  += 64'(bt.blue);
                    acc_green += 64'(bt.green);
                    acc_red   += 64'(bt.red);
                    acc_pixels++;
                end
                if (bt.frame_end) begin
                    total = acc_blue + acc_green + acc_red;
                    wb_gain_blue  = gray_world_gain(total, acc_blue, acc_pixels);
                    wb_gain_green = gray_world_gain(total, acc_green, acc_pixels);
                    wb_gain_red   = gray_world_gain(total, acc_red, acc_pixels);
                    cal_running   = 1'b0;
                end
            end
            frame_start = bt.frame_end;
        end
    endtask

    task automatic send_beat(beat_t bt);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= bt.op;
        s_blue_in   <= bt.blue;
        s_green_in  <= bt.green;
        s_red_in    <= bt.red;
        s_frame_end <= bt.frame_end;
        do @(posedge aclk); while (!s_ready);
        balance_beat(bt);
    endtask

    function automatic beat_t make_beat(logic [1:0] op, logic [7:0] b, logic [7:0] g,
                                        logic [7:0] r, logic fe);
        beat_t bt;
        bt = '0;
        bt.op        = op;
        bt.blue      = b;
        bt.green     = g;
        bt.red       = r;
        bt.frame_end = fe;
        return bt;
    endfunction

    task automatic plan(logic [1:0] op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                        logic fe, logic fixed = 1'b0, logic [7:0] want_r = 8'd0,
                        logic [7:0] want_g = 8'd0, logic [7:0] want_b = 8'd0);
        beat_t bt;
        bt = make_beat(op, b, g, r, fe);
        bt.fixed = fixed;
        bt.want  = '{red: want_r, green: want_g, blue: want_b, frame_end: fe};
        directed_beats.push_back(bt);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (balanced_pixels.size() != 0);
    endtask

    task automatic send_control();
        int pick;
        pick = $urandom_range(0, 2);
        send_beat(make_beat(pick == 0 ? OP_ARM : (pick == 1 ? OP_UNITY : OP_UNUSED),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    // one frame with its own brightness per channel, so the gains wander
    task automatic send_frame();
        int len;
        int lo[3];
        int hi[3];
        int ch_pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        for (int c = 0; c < 3; c++) begin
            ch_pick = $urandom_range(0, 4);
            case (ch_pick)
                0: begin lo[c] = 0;   hi[c] = 1;   end
                1: begin lo[c] = 0;   hi[c] = 255; end
                2: begin lo[c] = 200; hi[c] = 255; end
                3: begin lo[c] = 0;   hi[c] = 40;  end
                default: begin lo[c] = 60; hi[c] = 180; end
            endcase
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0)
                send_control();
            send_beat(make_beat(OP_PIXEL, 8'($urandom_range(lo[0], hi[0])),
                                8'($urandom_range(lo[1], hi[1])),
                                8'($urandom_range(lo[2], hi[2])), i == len - 1));
        end
    endtask

    task automatic report(string what, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // result side
    initial begin
        int gap;
        bit calm;
        bit stalled;
        pixel_out_t want;
        calm    = 1'b0;
        stalled = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 15);
            // one long hold-off so the block backs up onto its input
            if (!stalled && results_seen == 150) begin
                stalled = 1'b1;
                gap = STALL_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (balanced_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: pixel beat with nothing expected, got r=%0d g=%0d b=%0d fe=%0d",
                         $time, m_red_out, m_green_out, m_blue_out, m_frame_end_out);
            end else begin
                want = balanced_pixels.pop_front();
                if (m_red_out !== want.red)
                    report("red_out", int'(want.red), int'(m_red_out));
                if (m_green_out !== want.green)
                    report("green_out", int'(want.green), int'(m_green_out));
                if (m_blue_out !== want.blue)
                    report("blue_out", int'(want.blue), int'(m_blue_out));
                if (m_frame_end_out !== want.frame_end)
                    report("frame_end_out", int'(want.frame_end), int'(m_frame_end_out));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int pick;
        bit paused;
        paused = 1'b0;
        reset_balance_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unity gains straight after reset
        plan(OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        plan(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        plan(OP_PIXEL, 8'h55, 8'hAA, 8'h01, 1'b1, 1'b1, 8'h01, 8'hAA, 8'h55);
        plan(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // measured frame still leaves with the old gains
        plan(OP_ARM, 8'h00, 8'h00, 8'h00, 1'b0);
        plan(OP_PIXEL, 8'd200, 8'd100, 8'd50, 1'b0, 1'b1, 8'd50, 8'd100, 8'd200);
        plan(OP_PIXEL, 8'd200, 8'd100, 8'd50, 1'b1, 1'b1, 8'd50, 8'd100, 8'd200);
        plan(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        plan(OP_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0);
        // arm mid-frame waits for the next frame start
        plan(OP_ARM, 8'h00, 8'h00, 8'h00, 1'b0);
        plan(OP_PIXEL, 8'h80, 8'h40, 8'h20, 1'b1);
        plan(OP_PIXEL, 8'd0, 8'd255, 8'd1, 1'b0);
        // unity mid-measure keeps the measurement going; red ends at the 3.0 ceiling
        plan(OP_UNITY, 8'h00, 8'h00, 8'h00, 1'b0);
        plan(OP_PIXEL, 8'd0, 8'd255, 8'd1, 1'b1, 1'b1, 8'd1, 8'd255, 8'd0);
        plan(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // re-arm while measuring: the next frame is measured again
        plan(OP_ARM, 8'h00, 8'h00, 8'h00, 1'b0);
        plan(OP_PIXEL, 8'd1, 8'hFE, 8'h7F, 1'b0);
        plan(OP_ARM, 8'h00, 8'h00, 8'h00, 1'b0);
        plan(OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        plan(OP_PIXEL, 8'h2A, 8'h2A, 8'h2A, 1'b1);
        plan(OP_PIXEL, 8'h10, 8'hC0, 8'h90, 1'b1);
        plan(OP_UNITY, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        plan(OP_PIXEL, 8'hAA, 8'h55, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'h55, 8'hAA);

        foreach (directed_beats[i])
            send_beat(directed_beats[i]);

        beats_counted = 0;
        while (beats_counted < RANDOM_BEATS) begin
            if (!paused && beats_counted >= 350) begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame();
            else if (pick < 75)
                send_beat(make_beat(OP_ARM, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
            else if (pick < 82)
                send_beat(make_beat(OP_UNITY, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
            else
                send_beat(make_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1))));
        end

        s_valid <= 1'b0;
        while (balanced_pixels.size() != 0) @(posedge aclk);
        repeat (DIV_CYCLES + 20) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
